@@ hw/rtl/mrte_pkg.sv @@
// Shared codes and types for the R-type execute unit.
`default_nettype none

package mrte_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned SHW  = 5;

  // funct codes
  localparam logic [5:0] F_SLL  = 6'h00;
  localparam logic [5:0] F_SRL  = 6'h02;
  localparam logic [5:0] F_SRA  = 6'h03;
  localparam logic [5:0] F_SLLV = 6'h04;
  localparam logic [5:0] F_SRLV = 6'h06;
  localparam logic [5:0] F_SRAV = 6'h07;
  localparam logic [5:0] F_JR   = 6'h08;
  localparam logic [5:0] F_MFHI = 6'h10;
  localparam logic [5:0] F_MTHI = 6'h11;
  localparam logic [5:0] F_MFLO = 6'h12;
  localparam logic [5:0] F_MTLO = 6'h13;
  localparam logic [5:0] F_DIV  = 6'h1A;
  localparam logic [5:0] F_DIVU = 6'h1B;
  localparam logic [5:0] F_ADD  = 6'h20;
  localparam logic [5:0] F_ADDU = 6'h21;
  localparam logic [5:0] F_SUB  = 6'h22;
  localparam logic [5:0] F_SUBU = 6'h23;
  localparam logic [5:0] F_AND  = 6'h24;
  localparam logic [5:0] F_OR   = 6'h25;
  localparam logic [5:0] F_XOR  = 6'h26;
  localparam logic [5:0] F_NOR  = 6'h27;
  localparam logic [5:0] F_SLT  = 6'h2A;
  localparam logic [5:0] F_SLTU = 6'h2B;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;

  typedef enum logic [3:0] {
    ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR, ALU_NOR,
    ALU_SLT, ALU_SLTU, ALU_SLL, ALU_SRL, ALU_SRA
  } alu_op_t;

  typedef struct packed {
    logic             start;
    alu_op_t          op;
    logic [SHW-1:0]   amount;
  } alu_ctrl_t;

  typedef struct packed {
    logic start;
    logic is_signed;
  } div_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/mrte_alu.sv @@
// Bit-serial ALU: add, subtract, logic and compare one bit a cycle, shifts one place a cycle.
`default_nettype none

module mrte_alu
  import mrte_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  alu_ctrl_t       ctrl,
  input  logic [XLEN-1:0] a_in,
  input  logic [XLEN-1:0] b_in,
  output logic            done,
  output logic [XLEN-1:0] result
);

  logic            busy;
  alu_op_t         op;
  logic [SHW-1:0]  cnt;
  logic [XLEN-1:0] a_sh;
  logic [XLEN-1:0] b_sh;
  logic [XLEN-1:0] acc;
  logic            carry;

  logic is_shift;
  logic is_sub;
  logic start_sub;
  logic last;
  logic flip;
  logic abit;
  logic bbit;
  logic sum;
  logic cout;
  logic rbit;

  always_comb begin
    is_shift  = (op inside {ALU_SLL, ALU_SRL, ALU_SRA});
    is_sub    = (op inside {ALU_SUB, ALU_SLT, ALU_SLTU});
    start_sub = (ctrl.op inside {ALU_SUB, ALU_SLT, ALU_SLTU});
    last      = (cnt == '0);
    // signed compare: flip the sign bits and compare unsigned
    flip      = last && (op == ALU_SLT);
    abit      = a_sh[0] ^ flip;
    bbit      = b_sh[0] ^ flip ^ is_sub;
    sum       = abit ^ bbit ^ carry;
    cout      = (abit & bbit) | (abit & carry) | (bbit & carry);
    case (op)
      ALU_AND: rbit = a_sh[0] & b_sh[0];
      ALU_OR:  rbit = a_sh[0] | b_sh[0];
      ALU_XOR: rbit = a_sh[0] ^ b_sh[0];
      ALU_NOR: rbit = ~(a_sh[0] | b_sh[0]);
      default: rbit = sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        op    <= ctrl.op;
        a_sh  <= a_in;
        b_sh  <= b_in;
        acc   <= b_in;
        carry <= start_sub;
        cnt   <= (ctrl.op inside {ALU_SLL, ALU_SRL, ALU_SRA}) ? ctrl.amount : SHW'(XLEN - 1);
      end else if (busy) begin
        if (is_shift) begin
          if (last) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt - 1'b1;
            case (op)
              ALU_SLL: acc <= {acc[XLEN-2:0], 1'b0};
              ALU_SRL: acc <= {1'b0, acc[XLEN-1:1]};
              default: acc <= {acc[XLEN-1], acc[XLEN-1:1]};
            endcase
          end
        end else begin
          a_sh  <= {1'b0, a_sh[XLEN-1:1]};
          b_sh  <= {1'b0, b_sh[XLEN-1:1]};
          carry <= cout;
          // no carry out of a subtract means a borrow: less than
          if (last && (op inside {ALU_SLT, ALU_SLTU})) begin
            acc <= {{(XLEN-1){1'b0}}, ~cout};
          end else begin
            acc <= {rbit, acc[XLEN-1:1]};
          end
          if (last) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
      end
    end
  end

  assign result = acc;

endmodule

`default_nettype wire

@@ hw/rtl/mrte_div.sv @@
// Radix-2 restoring divider, one quotient bit a cycle, with sign fixup.
`default_nettype none

module mrte_div
  import mrte_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  div_ctrl_t       ctrl,
  input  logic [XLEN-1:0] dividend,
  input  logic [XLEN-1:0] divisor,
  output logic            done,
  output logic [XLEN-1:0] quotient,
  output logic [XLEN-1:0] remainder
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX} state_t;

  state_t          state;
  logic [SHW-1:0]  cnt;
  logic [XLEN-1:0] quo;
  logic [XLEN-1:0] rem;
  logic [XLEN-1:0] dvs;
  logic            q_neg;
  logic            r_neg;

  logic            s_neg;
  logic            t_neg;
  logic [XLEN:0]   rem_sh;
  logic [XLEN+1:0] diff;
  logic            ge;

  always_comb begin
    s_neg  = ctrl.is_signed & dividend[XLEN-1];
    t_neg  = ctrl.is_signed & divisor[XLEN-1];
    rem_sh = {rem, quo[XLEN-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs};
    ge     = ~diff[XLEN+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            quo   <= s_neg ? (~dividend + XLEN'(1)) : dividend;
            dvs   <= t_neg ? (~divisor + XLEN'(1)) : divisor;
            rem   <= '0;
            q_neg <= s_neg ^ t_neg;
            r_neg <= s_neg;
            cnt   <= SHW'(XLEN - 1);
            state <= S_RUN;
          end
        end
        S_RUN: begin
          rem <= ge ? diff[XLEN-1:0] : rem_sh[XLEN-1:0];
          quo <= {quo[XLEN-2:0], ge};
          if (cnt == '0) begin
            state <= S_FIX;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_FIX: begin
          if (q_neg) quo <= ~quo + XLEN'(1);
          if (r_neg) rem <= ~rem + XLEN'(1);
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

@@ hw/rtl/mips_r_type_execute.sv @@
// Top level of the MIPS32 R-type execute unit with HI and LO registers.
//
//  channel  dir  tdata                                   tuser
//  s_axis   in   rs_value, rt_value, shift_amount        req_type (funct)
//  m_axis   out  rd_value, pc_target                     rd_write, pc_write, status
//
// One request at a time. Path from accepted request to result on m_axis:
// jr, mfhi/mflo, mthi/mtlo and rejected requests go to the output register;
// shifts, add, sub, logic and compare run in the bit-serial ALU (all 32 bits
// but for shifts); div and divu run 32 restoring steps plus a sign fixup.
// rst clears control state and HI/LO. A stalled m_axis holds the result in the
// output register while the next request is taken and worked on.
`default_nettype none

module mips_r_type_execute
  import mrte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // rs_value[31:0], rt_value[63:32], shift_amount[68:64], zero
  input  logic [5:0]  s_axis_tuser,  // req_type[5:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // rd_value[31:0], pc_target[63:32]
  output logic [3:0]  m_axis_tuser   // rd_write[0], pc_write[1], status[3:2]
);

  typedef enum logic [1:0] {S_IDLE, S_ALU, S_DIV, S_HOLD} state_t;

  state_t state;

  // architectural HI/LO
  logic [XLEN-1:0] hi_reg;
  logic [XLEN-1:0] lo_reg;

  // result held until the output register is free
  logic [XLEN-1:0] res_rd;
  logic            res_wr;
  logic            res_pcw;
  logic [XLEN-1:0] res_target;
  logic [1:0]      res_status;

  // request fields
  logic [5:0]      req_type;
  logic [XLEN-1:0] rs_value;
  logic [XLEN-1:0] rt_value;
  logic [SHW-1:0]  shift_amount;
  logic            accept;
  logic            out_load;

  assign req_type     = s_axis_tuser;
  assign rs_value     = s_axis_tdata[31:0];
  assign rt_value     = s_axis_tdata[63:32];
  assign shift_amount = s_axis_tdata[68:64];
  assign s_axis_tready = (state == S_IDLE);
  assign accept       = s_axis_tvalid && s_axis_tready;
  // move the held result out when the output register is empty or being drained
  assign out_load     = (state == S_HOLD) && (!m_axis_tvalid || m_axis_tready);

  // decode
  alu_ctrl_t       alu_ctrl;
  div_ctrl_t       div_ctrl;
  logic            use_alu;
  logic            use_div;
  alu_op_t         dec_op;
  logic [SHW-1:0]  dec_amount;
  logic [XLEN-1:0] dec_rd;
  logic            dec_wr;
  logic            dec_pcw;
  logic [XLEN-1:0] dec_target;
  logic [1:0]      dec_status;
  logic            dec_hi_wr;
  logic            dec_lo_wr;

  always_comb begin
    use_alu    = 1'b0;
    use_div    = 1'b0;
    dec_op     = ALU_ADD;
    dec_amount = shift_amount;
    dec_rd     = '0;
    dec_wr     = 1'b0;
    dec_pcw    = 1'b0;
    dec_target = '0;
    dec_status = ST_OK;
    dec_hi_wr  = 1'b0;
    dec_lo_wr  = 1'b0;
    case (req_type)
      F_SLL:  begin use_alu = 1'b1; dec_op = ALU_SLL; end
      F_SRL:  begin use_alu = 1'b1; dec_op = ALU_SRL; end
      F_SRA:  begin use_alu = 1'b1; dec_op = ALU_SRA; end
      F_SLLV: begin use_alu = 1'b1; dec_op = ALU_SLL; dec_amount = rs_value[SHW-1:0]; end
      F_SRLV: begin use_alu = 1'b1; dec_op = ALU_SRL; dec_amount = rs_value[SHW-1:0]; end
      F_SRAV: begin use_alu = 1'b1; dec_op = ALU_SRA; dec_amount = rs_value[SHW-1:0]; end
      F_ADD, F_ADDU: begin use_alu = 1'b1; dec_op = ALU_ADD; end
      F_SUB, F_SUBU: begin use_alu = 1'b1; dec_op = ALU_SUB; end
      F_AND:  begin use_alu = 1'b1; dec_op = ALU_AND; end
      F_OR:   begin use_alu = 1'b1; dec_op = ALU_OR; end
      F_XOR:  begin use_alu = 1'b1; dec_op = ALU_XOR; end
      F_NOR:  begin use_alu = 1'b1; dec_op = ALU_NOR; end
      F_SLT:  begin use_alu = 1'b1; dec_op = ALU_SLT; end
      F_SLTU: begin use_alu = 1'b1; dec_op = ALU_SLTU; end
      F_JR: begin
        dec_pcw    = 1'b1;
        dec_target = rs_value;
      end
      F_MFHI: begin dec_wr = 1'b1; dec_rd = hi_reg; end
      F_MFLO: begin dec_wr = 1'b1; dec_rd = lo_reg; end
      F_MTHI: dec_hi_wr = 1'b1;
      F_MTLO: dec_lo_wr = 1'b1;
      F_DIV, F_DIVU: begin
        // divide by zero: flag and leave HI/LO alone
        if (rt_value == '0) dec_status = ST_DIV0;
        else use_div = 1'b1;
      end
      default: dec_status = ST_UNSUP;
    endcase
    if (use_alu) dec_wr = 1'b1;

    alu_ctrl.start     = accept && use_alu;
    alu_ctrl.op        = dec_op;
    alu_ctrl.amount    = dec_amount;
    div_ctrl.start     = accept && use_div;
    div_ctrl.is_signed = (req_type == F_DIV);
  end

  logic            alu_done;
  logic [XLEN-1:0] alu_result;
  logic            div_done;
  logic [XLEN-1:0] div_quo;
  logic [XLEN-1:0] div_rem;

  mrte_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (alu_ctrl),
    .a_in   (rs_value),
    .b_in   (rt_value),
    .done   (alu_done),
    .result (alu_result)
  );

  mrte_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (rs_value),
    .divisor   (rt_value),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      hi_reg        <= '0;
      lo_reg        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // drop the output once the consumer takes it, unless a new result moves in
      if (m_axis_tvalid && m_axis_tready && !out_load) m_axis_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            res_rd     <= dec_rd;
            res_wr     <= dec_wr;
            res_pcw    <= dec_pcw;
            res_target <= dec_target;
            res_status <= dec_status;
            if (dec_hi_wr) hi_reg <= rs_value;
            if (dec_lo_wr) lo_reg <= rs_value;
            if (use_alu)      state <= S_ALU;
            else if (use_div) state <= S_DIV;
            else              state <= S_HOLD;
          end
        end
        S_ALU: begin
          if (alu_done) begin
            res_rd <= alu_result;
            state  <= S_HOLD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            hi_reg <= div_rem;
            lo_reg <= div_quo;
            state  <= S_HOLD;
          end
        end
        S_HOLD: begin
          // advance into the output register when it is free
          if (out_load) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {res_target, res_rd};
            m_axis_tuser  <= {res_status, res_pcw, res_wr};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
